@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the queue RTL, used by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define SPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/spq_pkg.sv @@
// Types, codes and defaults for the sorted priority queue.
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int PRI_BITS_DEF = 16;

	localparam logic [1:0] FN_PUSH  = 2'd0;
	localparam logic [1:0] FN_POP   = 2'd1;
	localparam logic [1:0] FN_PEEK  = 2'd2;
	// Unused code, handled as a peek.
	localparam logic [1:0] FN_SPARE = 2'd3;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_PUSH_FULL = 2'd1;
	localparam logic [1:0] ST_POP_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] item_value;
		logic signed [15:0] item_priority;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] head_value;
		logic signed [15:0] head_priority;
		logic [4:0]         entry_count;
		logic               is_empty;
		logic               is_full;
		logic [1:0]         status;
	} result_t;

	// Per-cycle control broadcast to every cell.
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

@@ hw/rtl/sorted_priority_queue_top.sv @@
// Sorted priority queue: a chain of compare-and-shift cells with a fill counter.
//
// Takes one command (push, pop head, peek) in every cycle: busy stays low, and
// the result for a command accepted at one clock edge shows on result with done
// high during the following cycle, for that cycle only. Every cell compares its
// priority with the pushed one and shifts in parallel; the cell row of CAPACITY
// slots is the whole store. Lower priority numbers sit nearer the head, equal
// priorities leave first in, first out. A push to a full queue or a pop from an
// empty one leaves the queue as it is and is flagged in status. The head fields
// read zero while the queue is empty.
module sorted_priority_queue_top import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int PRI_BITS = PRI_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

`include "assert_macros.svh"

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]   count_q;
	logic [1:0]      status_q;
	logic            done_q;
	logic            full;
	logic            empty;
	logic            push_ok;
	logic            pop_ok;
	cell_ctl_t       ctl;
	logic signed [PRI_BITS-1:0] new_pri;

	logic                       after_w [CAPACITY];
	logic signed [31:0]         value_w [CAPACITY];
	logic signed [PRI_BITS-1:0] pri_w   [CAPACITY];
	logic [CAPACITY-1:0]        occ;

	assign busy  = 1'b0;
	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	assign push_ok  = start && (cmd.func == FN_PUSH) && !full;
	assign pop_ok   = start && (cmd.func == FN_POP) && !empty;
	assign ctl.push = push_ok;
	assign ctl.pop  = pop_ok;
	assign new_pri  = PRI_BITS'(cmd.item_priority);

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic                       l_after;
			logic signed [31:0]         l_value;
			logic signed [PRI_BITS-1:0] l_pri;
			logic signed [31:0]         r_value;
			logic signed [PRI_BITS-1:0] r_pri;

			assign occ[i] = (count_q > CW'(i));

			if (i == 0) begin : g_head
				assign l_after = 1'b1;
				assign l_value = '0;
				assign l_pri   = '0;
			end else begin : g_body
				assign l_after = after_w[i-1];
				assign l_value = value_w[i-1];
				assign l_pri   = pri_w[i-1];
			end

			if (i == CAPACITY - 1) begin : g_tail
				assign r_value = '0;
				assign r_pri   = '0;
			end else begin : g_inner
				assign r_value = value_w[i+1];
				assign r_pri   = pri_w[i+1];
			end

			spq_cell #(
				.PRI_BITS(PRI_BITS)
			) u_cell (
				.clk           (clk),
				.ctl           (ctl),
				.occupied      (occ[i]),
				.new_value     (cmd.item_value),
				.new_priority  (new_pri),
				.left_after    (l_after),
				.left_value    (l_value),
				.left_priority (l_pri),
				.right_value   (r_value),
				.right_priority(r_pri),
				.after         (after_w[i]),
				.value         (value_w[i]),
				.priority_o    (pri_w[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ST_DONE;
			done_q   <= 1'b0;
		end else begin
			done_q <= start;
			if (push_ok) begin
				count_q <= count_q + CW'(1);
			end else if (pop_ok) begin
				count_q <= count_q - CW'(1);
			end
			if (start) begin
				if (cmd.func == FN_PUSH && full) begin
					status_q <= ST_PUSH_FULL;
				end else if (cmd.func == FN_POP && empty) begin
					status_q <= ST_POP_EMPTY;
				end else begin
					status_q <= ST_DONE;
				end
			end
		end
	end

	assign done                 = done_q;
	assign result.head_value    = empty ? 32'sd0 : value_w[0];
	assign result.head_priority = empty ? 16'sd0 : 16'(pri_w[0]);
	assign result.entry_count   = 5'(count_q);
	assign result.is_empty      = empty;
	assign result.is_full       = full;
	assign result.status        = status_q;

	`SPQ_ASSERT(a_done_follows_start, (start && !busy) |=> done, "command gave no result")
	`SPQ_ASSERT(a_no_spurious_done, !(start && !busy) |=> !done, "result without command")
	`SPQ_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "fill count above capacity")
	`SPQ_ASSERT(a_head_order, occ[1] |-> (pri_w[0] <= pri_w[1]), "head not most urgent")
	`SPQ_ASSERT(a_full_refusal, (done && status_q == ST_PUSH_FULL) |-> full, "refused push while not full")

endmodule

@@ hw/rtl/spq_cell.sv @@
// One slot of the sorted chain: keep, take the new word, or shift from a neighbor.
module spq_cell import spq_pkg::*; #(
	parameter int PRI_BITS = PRI_BITS_DEF
) (
	input  logic                       clk,
	input  cell_ctl_t                  ctl,
	input  logic                       occupied,
	input  logic signed [31:0]         new_value,
	input  logic signed [PRI_BITS-1:0] new_priority,
	input  logic                       left_after,
	input  logic signed [31:0]         left_value,
	input  logic signed [PRI_BITS-1:0] left_priority,
	input  logic signed [31:0]         right_value,
	input  logic signed [PRI_BITS-1:0] right_priority,
	output logic                       after,
	output logic signed [31:0]         value,
	output logic signed [PRI_BITS-1:0] priority_o
);

	logic signed [31:0]         value_q;
	logic signed [PRI_BITS-1:0] priority_q;

	// Equal priorities stay ahead of the new word: first in, first out.
	assign after      = occupied && (priority_q <= new_priority);
	assign value      = value_q;
	assign priority_o = priority_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (!after) begin
				if (left_after) begin
					value_q    <= new_value;
					priority_q <= new_priority;
				end else begin
					value_q    <= left_value;
					priority_q <= left_priority;
				end
			end
		end else if (ctl.pop) begin
			value_q    <= right_value;
			priority_q <= right_priority;
		end
	end

endmodule
